[hdl/kcl_pkg.sv]
// Shared types and constants of the keypad code lock.
`default_nettype none

package kcl_pkg;

  // Operation carried by one input transaction.
  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_ENABLE = 2'd1,
    OP_DOOR   = 2'd2
  } opcode_e;

  // Event reported for every input transaction.
  typedef enum logic [3:0] {
    EV_DIGIT    = 4'd0,
    EV_DELETED  = 4'd1,
    EV_OPEN     = 4'd2,
    EV_WRONG    = 4'd3,
    EV_LOCKED   = 4'd4,
    EV_CHANGE   = 4'd5,
    EV_BADCUR   = 4'd6,
    EV_REPEAT   = 4'd7,
    EV_CHANGED  = 4'd8,
    EV_MISMATCH = 4'd9,
    EV_UNLOCKED = 4'd10,
    EV_IGNORED  = 4'd11
  } event_e;

  // Lock modes, one-hot.
  typedef enum logic [4:0] {
    MODE_NORMAL  = 5'b00001,
    MODE_CURRENT = 5'b00010,
    MODE_NEW1    = 5'b00100,
    MODE_NEW2    = 5'b01000,
    MODE_LOCKED  = 5'b10000
  } mode_e;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic {
    REG_MODE_CODE = 1'b0,
    REG_ATTEMPTS  = 1'b1
  } reg_idx_e;

  localparam int unsigned FIELD_CODE_W = 20;
  localparam int unsigned ATTEMPT_W    = 3;
  localparam int unsigned COUNT_OUT_W  = 3;

  localparam logic [3:0]              KEY_DELETE      = 4'd15;
  localparam logic [FIELD_CODE_W-1:0] MODE_CODE_RST   = 20'd920844;
  localparam logic [ATTEMPT_W-1:0]    ATTEMPTS_RST    = 3'd3;
  localparam logic [FIELD_CODE_W-1:0] STORED_CODE_RST = 20'd344592;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic       value_bit;
    logic [3:0] key_code;
    opcode_e    opcode;
  } in_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [FIELD_CODE_W-1:0] new_code;
    logic                    door_drive;
    logic [COUNT_OUT_W-1:0]  entry_count;
    event_e                  event_res;
  } res_t;

  // Configuration values handed from the register block to the core.
  typedef struct packed {
    logic [FIELD_CODE_W-1:0] mode_change_code;
    logic [ATTEMPT_W-1:0]    attempts_before_lock;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/kcl_cfg.sv]
// Configuration registers of the keypad code lock behind an APB-style port.
`default_nettype none

module kcl_cfg
  import kcl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [FIELD_CODE_W-1:0] mode_code_q;
  logic [ATTEMPT_W-1:0]    attempts_q;
  logic                    wr_en;
  reg_idx_e                reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_code_q <= MODE_CODE_RST;
      attempts_q  <= ATTEMPTS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE_CODE: mode_code_q <= pwdata[FIELD_CODE_W-1:0];
        REG_ATTEMPTS:  attempts_q  <= pwdata[ATTEMPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data is selected straight from the registers.
  always_comb begin
    case (reg_idx)
      REG_MODE_CODE: prdata = {{(32-FIELD_CODE_W){1'b0}}, mode_code_q};
      REG_ATTEMPTS:  prdata = {{(32-ATTEMPT_W){1'b0}}, attempts_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.mode_change_code     = mode_code_q;
  assign cfg_o.attempts_before_lock = attempts_q;

endmodule

`default_nettype wire

[hdl/kcl_core.sv]
// Input register, lock state, single-pass step logic and result register.
`default_nettype none

module kcl_core
  import kcl_pkg::*;
#(
  parameter int unsigned CODE_LEN = 5
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output res_t          out_res_o
);

  localparam int unsigned CODE_W  = 4 * CODE_LEN;
  localparam int unsigned STORE_W = (CODE_W > FIELD_CODE_W) ? CODE_W : FIELD_CODE_W;
  localparam int unsigned CNT_W   = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CODE_LEN - 1);

  // Pipeline registers.
  logic     in_vld_q;
  in_item_t in_item_q;
  logic     out_vld_q;
  res_t     out_res_q;

  // Lock state.
  mode_e                mode_q, mode_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ATTEMPT_W-1:0] wrong_q, wrong_d;
  logic [STORE_W-1:0]   stored_q, stored_d;
  logic [CODE_W-1:0]    first_q;
  logic                 first_wr;
  logic                 enabled_q, enabled_d;
  logic [3:0]           digits_q [CODE_LEN];
  logic                 digit_wr;

  logic               adv;
  logic               step_en;
  event_e             ev;
  logic [CODE_W-1:0]  entry;
  logic [STORE_W-1:0] mode_code_w;
  logic [ATTEMPT_W:0] wrong_inc;

  // Handshake: the result register frees when empty or taken, and the input
  // register refills whenever its item moves on.
  assign adv        = !out_vld_q || out_ready_i;
  assign step_en    = in_vld_q && adv;
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Full entry as it stands with the current key placed in its slot.
  always_comb begin
    for (int i = 0; i < CODE_LEN; i++) begin
      entry[4*i +: 4] = (CNT_W'(i) == count_q) ? in_item_q.key_code : digits_q[i];
    end
  end

  assign mode_code_w = STORE_W'(cfg_i.mode_change_code);
  assign wrong_inc   = {1'b0, wrong_q} + 1'b1;

  // Step logic for one transaction.
  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    wrong_d   = wrong_q;
    stored_d  = stored_q;
    enabled_d = enabled_q;
    first_wr  = 1'b0;
    digit_wr  = 1'b0;
    ev        = EV_IGNORED;
    case (in_item_q.opcode)
      OP_KEY: begin
        if (!enabled_q || mode_q == MODE_LOCKED) begin
          ev = EV_IGNORED;
        end else if (in_item_q.key_code == KEY_DELETE) begin
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
            ev      = EV_DELETED;
          end
        end else if (count_q != LAST_IDX) begin
          digit_wr = 1'b1;
          count_d  = count_q + 1'b1;
          ev       = EV_DIGIT;
        end else begin
          // Last digit: judge the full entry and empty it.
          digit_wr = 1'b1;
          count_d  = '0;
          case (mode_q)
            MODE_NORMAL: begin
              if (entry == stored_q[CODE_W-1:0]) begin
                ev      = EV_OPEN;
                wrong_d = '0;
              end else if (entry == mode_code_w[CODE_W-1:0]) begin
                ev     = EV_CHANGE;
                mode_d = MODE_CURRENT;
              end else if (wrong_inc >= {1'b0, cfg_i.attempts_before_lock}) begin
                ev        = EV_LOCKED;
                mode_d    = MODE_LOCKED;
                enabled_d = 1'b0;
                wrong_d   = '0;
              end else begin
                ev      = EV_WRONG;
                wrong_d = wrong_inc[ATTEMPT_W-1:0];
              end
            end
            MODE_CURRENT: begin
              if (entry == stored_q[CODE_W-1:0]) begin
                ev     = EV_CHANGE;
                mode_d = MODE_NEW1;
              end else begin
                ev     = EV_BADCUR;
                mode_d = MODE_NORMAL;
              end
            end
            MODE_NEW1: begin
              first_wr = 1'b1;
              ev       = EV_REPEAT;
              mode_d   = MODE_NEW2;
            end
            MODE_NEW2: begin
              if (entry == first_q) begin
                stored_d = STORE_W'(entry);
                ev       = EV_CHANGED;
              end else begin
                ev = EV_MISMATCH;
              end
              mode_d = MODE_NORMAL;
            end
            default: begin
              mode_d = MODE_NORMAL;
            end
          endcase
        end
      end
      OP_ENABLE: begin
        enabled_d = in_item_q.value_bit;
        if (in_item_q.value_bit) begin
          ev = EV_UNLOCKED;
          if (mode_q == MODE_LOCKED) begin
            mode_d  = MODE_NORMAL;
            wrong_d = '0;
          end
        end
      end
      OP_DOOR: begin
        if (in_item_q.value_bit) begin
          ev = EV_OPEN;
        end
      end
      default: begin
        ev = EV_IGNORED;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      count_q   <= '0;
      wrong_q   <= '0;
      stored_q  <= STORE_W'(STORED_CODE_RST);
      enabled_q <= 1'b1;
    end else if (step_en) begin
      mode_q    <= mode_d;
      count_q   <= count_d;
      wrong_q   <= wrong_d;
      stored_q  <= stored_d;
      enabled_q <= enabled_d;
    end
  end

  // Entry digits and the first new code are written before they are read.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CODE_LEN; i++) begin
      if (step_en && digit_wr && count_q == CNT_W'(i)) begin
        digits_q[i] <= in_item_q.key_code;
      end
    end
    if (step_en && first_wr) begin
      first_q <= entry;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_res_q.event_res   <= ev;
      out_res_q.entry_count <= COUNT_OUT_W'(count_d);
      out_res_q.door_drive  <= (ev == EV_OPEN);
      out_res_q.new_code    <= stored_d[FIELD_CODE_W-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

[hdl/keypad_code_lock_top.sv]
// Keypad code lock: stream in, stream out, APB-style configuration.
//
// Each input transaction on s_axis carries a key press or a remote command;
// every one gives exactly one result transaction on m_axis with the event,
// the digits held in the entry, the door drive and the stored code.
// Configuration: register 0 (address 0) is the mode-change code, register 1
// (address 4) is the number of wrong entries before lockout. Write them only
// while no transaction is in flight.
// Path: an accepted item waits in the input register until the result
// register is free, then moves into the result register and sits there
// until it is taken. Throughput: one transaction per cycle while the
// result side does not stall; the whole step, including the parallel code
// compares, is one pass of logic between those two registers.
// Reset: stored code keys 0, 1, 2, 4, 5, mode code keys 12, 0, 13, 0, 14,
// three attempts, keypad enabled, entry empty, both pipeline registers empty.
// Stall: when m_axis_tready is low the result holds, the input register
// still takes one more transaction, then s_axis_tready drops.
`default_nettype none

module keypad_code_lock_top
  import kcl_pkg::*;
#(
  parameter int unsigned CODE_LEN = 5  // digits per code, 1 to 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0: opcode[1:0], key_code[5:2], value_bit[6], zero[7]
  input  wire logic [7:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: event_res[3:0], entry_count[6:4], door_drive[7],
  // new_code[27:8], zero[31:28]
  output logic [31:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t     cfg;
  in_item_t in_item;
  res_t     out_res;

  assign in_item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);

  kcl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kcl_core #(
    .CODE_LEN (CODE_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {{(32-$bits(res_t)){1'b0}}, out_res};

endmodule

`default_nettype wire

[tb/sv/keypad_code_lock_checker.sv]
// Checker for the keypad code lock: predicts each result and compares it.
`timescale 1ns / 1ps

module keypad_code_lock_checker
  import kcl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  // tdata from bit 0: opcode[1:0], key_code[5:2], value_bit[6], zero[7]
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: event_res[3:0], entry_count[6:4], door_drive[7],
  // new_code[27:8], zero[31:28]
  input  wire logic [31:0] m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int unsigned DIGITS = 5;
  localparam int unsigned MAX_REPORTS = 60;

  // Shadow of the lock state and its configuration.
  mode_e                   lk_mode;
  logic [FIELD_CODE_W-1:0] entry_r;
  logic [2:0]              digits_r;
  logic [2:0]              misses_r;
  logic [FIELD_CODE_W-1:0] code_r;
  logic [FIELD_CODE_W-1:0] first_r;
  logic                    keypad_on;
  logic [FIELD_CODE_W-1:0] cfg_mode_code;
  logic [ATTEMPT_W-1:0]    cfg_attempts;

  // Results still owed by the block, oldest first.
  res_t lock_results_q[$];
  res_t got;
  res_t want;

  // Judge a complete entry against the codes for the current mode.
  function automatic event_e judge_entry(input logic [FIELD_CODE_W-1:0] entry);
    event_e      ev;
    int unsigned tries;
    ev = EV_IGNORED;
    tries = 32'(misses_r) + 1;
    case (lk_mode)
      MODE_NORMAL: begin
        if (entry == code_r) begin
          ev = EV_OPEN;
          misses_r = '0;
        end else if (entry == cfg_mode_code) begin
          ev = EV_CHANGE;
          lk_mode = MODE_CURRENT;
        end else if (tries >= 32'(cfg_attempts)) begin
          ev = EV_LOCKED;
          lk_mode = MODE_LOCKED;
          keypad_on = 1'b0;
          misses_r = '0;
        end else begin
          ev = EV_WRONG;
          misses_r = misses_r + 3'd1;
        end
      end
      MODE_CURRENT: begin
        if (entry == code_r) begin
          ev = EV_CHANGE;
          lk_mode = MODE_NEW1;
        end else begin
          ev = EV_BADCUR;
          lk_mode = MODE_NORMAL;
        end
      end
      MODE_NEW1: begin
        first_r = entry;
        ev = EV_REPEAT;
        lk_mode = MODE_NEW2;
      end
      MODE_NEW2: begin
        if (entry == first_r) begin
          code_r = entry;
          ev = EV_CHANGED;
        end else begin
          ev = EV_MISMATCH;
        end
        lk_mode = MODE_NORMAL;
      end
      default: begin
        lk_mode = MODE_NORMAL;
      end
    endcase
    return ev;
  endfunction

  // One key press: digit, delete, or judgement of a full entry.
  function automatic event_e press_key(input logic [3:0] key);
    if (!keypad_on || lk_mode == MODE_LOCKED) return EV_IGNORED;
    if (key == KEY_DELETE) begin
      if (digits_r == 3'd0) return EV_IGNORED;
      digits_r = digits_r - 3'd1;
      return EV_DELETED;
    end
    entry_r[4*digits_r +: 4] = key;
    digits_r = digits_r + 3'd1;
    if (32'(digits_r) < DIGITS) return EV_DIGIT;
    digits_r = '0;
    return judge_entry(entry_r);
  endfunction

  // Advance the shadow by one input transaction and form its result.
  function automatic res_t lock_step(input logic [7:0] data);
    res_t       r;
    event_e     ev;
    logic [1:0] op;
    logic [3:0] key;
    logic       val;
    op  = data[1:0];
    key = data[5:2];
    val = data[6];
    ev  = EV_IGNORED;
    if (op == OP_KEY) begin
      ev = press_key(key);
    end else if (op == OP_ENABLE) begin
      keypad_on = val;
      if (val) begin
        ev = EV_UNLOCKED;
        if (lk_mode == MODE_LOCKED) begin
          lk_mode = MODE_NORMAL;
          misses_r = '0;
        end
      end
    end else if (op == OP_DOOR) begin
      if (val) ev = EV_OPEN;
    end
    r.event_res   = ev;
    r.entry_count = digits_r;
    r.door_drive  = (ev == EV_OPEN);
    r.new_code    = code_r;
    return r;
  endfunction

  // Report one field that differs from its prediction.
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      if (fail_count_o < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Watch all three ports; results are checked before new predictions go in.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_mode       = MODE_NORMAL;
      entry_r       = '0;
      digits_r      = '0;
      misses_r      = '0;
      code_r        = STORED_CODE_RST;
      first_r       = '0;
      keypad_on     = 1'b1;
      cfg_mode_code = MODE_CODE_RST;
      cfg_attempts  = ATTEMPTS_RST;
      lock_results_q.delete();
      fail_count_o  = 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(res_t)-1:0];
        if (lock_results_q.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("%0t ns: unexpected result, expected none, actual %h",
                     $time, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = lock_results_q.pop_front();
          check_field("event_res", 32'(want.event_res), 32'(got.event_res));
          check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
          check_field("door_drive", 32'(want.door_drive), 32'(got.door_drive));
          check_field("new_code", 32'(want.new_code), 32'(got.new_code));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_MODE_CODE: cfg_mode_code = pwdata[FIELD_CODE_W-1:0];
          REG_ATTEMPTS:  cfg_attempts  = pwdata[ATTEMPT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        lock_results_q.push_back(lock_step(s_axis_tdata));
      pending_o <= lock_results_q.size();
    end
  end

endmodule

[tb/sv/keypad_code_lock_top_tb.sv]
// Testbench top for the keypad code lock: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module keypad_code_lock_top_tb;
  import kcl_pkg::*;

  localparam logic [1:0] OP_SPARE       = 2'd3;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         HOLD_CYCLES    = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  int fail_count;
  int pending;

  // Stimulus bookkeeping: the code the lock should hold and the mode code.
  logic [FIELD_CODE_W-1:0] lock_code = STORED_CODE_RST;
  logic [FIELD_CODE_W-1:0] mode_code = MODE_CODE_RST;
  logic [ATTEMPT_W-1:0]    attempts  = ATTEMPTS_RST;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit mix_on = 1'b0;
  bit hold_req = 1'b0;
  bit dirty = 1'b1;

  keypad_code_lock_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  keypad_code_lock_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // End the run if no transaction of any kind completes for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall bursts, and one long hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Offer one transaction and wait until the block takes it.
  task automatic send_item(input logic [1:0] op, input logic [3:0] key,
                           input logic val);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, val, key, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Key in a whole code, with optional remote commands and corrections.
  task automatic press_code(input logic [FIELD_CODE_W-1:0] code);
    for (int i = 0; i < 5; i++) begin
      if (mix_on && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1))
          send_item(OP_DOOR, 4'($urandom), 1'($urandom));
        else
          send_item(OP_ENABLE, 4'($urandom), 1'b1);
      end
      // A mistyped digit fixed with delete; never on the final digit.
      if (mix_on && i < 4 && $urandom_range(0, 11) == 0) begin
        send_item(OP_KEY, 4'($urandom_range(0, 14)), 1'($urandom));
        send_item(OP_KEY, KEY_DELETE, 1'($urandom));
      end
      send_item(OP_KEY, code[4*i +: 4], 1'($urandom));
    end
  endtask

  function automatic logic [FIELD_CODE_W-1:0] rand_code();
    logic [FIELD_CODE_W-1:0] c;
    for (int i = 0; i < 5; i++) c[4*i +: 4] = 4'($urandom_range(0, 14));
    return c;
  endfunction

  // The mode code can start a change only if it is typeable and not the code.
  function automatic bit change_path_open();
    bit ok;
    ok = (mode_code != lock_code);
    for (int i = 0; i < 5; i++)
      if (mode_code[4*i +: 4] == KEY_DELETE) ok = 1'b0;
    return ok;
  endfunction

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_MODE_CODE) mode_code = value[FIELD_CODE_W-1:0];
    else attempts = value[ATTEMPT_W-1:0];
  endtask

  // Full code change, sometimes with the keypad disabled midway or a bad repeat.
  task automatic change_flow();
    logic [FIELD_CODE_W-1:0] nc;
    press_code(mode_code);
    if ($urandom_range(0, 4) == 0) begin
      send_item(OP_ENABLE, 4'($urandom), 1'b0);
      repeat ($urandom_range(1, 3)) send_item(OP_KEY, 4'($urandom), 1'($urandom));
      send_item(OP_ENABLE, 4'($urandom), 1'b1);
    end
    press_code(lock_code);
    nc = rand_code();
    while (nc == mode_code) nc = rand_code();
    press_code(nc);
    if ($urandom_range(0, 3) == 0) begin
      press_code(rand_code());
    end else begin
      press_code(nc);
      lock_code = nc;
    end
  endtask

  // Mostly well-formed sequences with random content, the rest noise.
  task automatic run_random(input int target);
    logic [FIELD_CODE_W-1:0] bad;
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (dirty) begin
        // Unlock, enable and empty any partial entry.
        send_item(OP_ENABLE, 4'($urandom), 1'b1);
        repeat (4) send_item(OP_KEY, KEY_DELETE, 1'($urandom));
        dirty = 1'b0;
      end
      if (pick < 40 && change_path_open()) begin
        change_flow();
      end else if (pick < 52 && change_path_open()) begin
        press_code(mode_code);
        bad = rand_code();
        while (bad == lock_code) bad = rand_code();
        press_code(bad);
      end else if (pick < 68) begin
        press_code(lock_code);
      end else if (pick < 78) begin
        press_code(rand_code());
        dirty = 1'b1;
      end else if (pick < 84) begin
        // Enough wrong entries to lock, then keys that must be ignored.
        repeat (attempts) begin
          bad = rand_code();
          while (bad == lock_code || bad == mode_code) bad = rand_code();
          press_code(bad);
        end
        repeat ($urandom_range(1, 2)) send_item(OP_KEY, 4'($urandom), 1'($urandom));
        dirty = 1'b1;
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(2'($urandom), 4'($urandom), 1'($urandom));
        dirty = 1'b1;
      end
    end
  endtask

  // Main stimulus.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every operation and the simple corner cases.
    send_item(OP_KEY, KEY_DELETE, 1'b0);
    send_item(OP_KEY, 4'd0, 1'b1);
    send_item(OP_KEY, 4'd14, 1'b0);
    send_item(OP_KEY, KEY_DELETE, 1'b1);
    send_item(OP_DOOR, 4'd15, 1'b1);
    send_item(OP_DOOR, 4'd0, 1'b0);
    send_item(OP_SPARE, 4'd15, 1'b1);
    send_item(OP_ENABLE, 4'd0, 1'b0);
    send_item(OP_KEY, 4'd7, 1'b1);
    send_item(OP_ENABLE, 4'd15, 1'b1);
    send_item(OP_KEY, KEY_DELETE, 1'b0);
    press_code(lock_code);
    press_code('0);
    drain();

    // Reset configuration, random traffic.
    mix_on = 1'b1;
    run_random(250);
    drain();

    // Mode code zero and one attempt; starts with a long result stall while the input keeps coming.
    write_reg(REG_MODE_CODE, 32'd0);
    write_reg(REG_ATTEMPTS, 32'd1);
    tx_idle  = 1'b0;
    hold_req = 1'b1;
    repeat (8) press_code(lock_code);
    tx_idle = 1'b1;
    run_random(500);
    drain();

    // Highest extremes: the mode code is all delete keys.
    write_reg(REG_MODE_CODE, 32'hFFFFF);
    write_reg(REG_ATTEMPTS, 32'd7);
    run_random(750);
    drain();

    // Random typeable mode code and a middle attempt count.
    write_reg(REG_MODE_CODE, 32'(rand_code()));
    write_reg(REG_ATTEMPTS, 32'($urandom_range(2, 6)));
    run_random(1000);
    drain();

    // Back to the reset settings, no idling on either side.
    write_reg(REG_MODE_CODE, 32'(MODE_CODE_RST));
    write_reg(REG_ATTEMPTS, 32'(ATTEMPTS_RST));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(1200);
    drain();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/kcl_pkg.sv
hdl/kcl_cfg.sv
hdl/kcl_core.sv
hdl/keypad_code_lock_top.sv
tb/sv/keypad_code_lock_checker.sv
tb/sv/keypad_code_lock_top_tb.sv
